### hdl/fmtm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the sine table builder for the FM tone modulator.
// Used by fmtm_sine_rom and fm_tone_modulator_top; depends on nothing else.
package fmtm_pkg;

	// Phase accumulator, table and message sum sizes.
	localparam int PHASE_BITS = 32;
	localparam int TABLE_BITS = 10;
	localparam int SUM_BITS   = 48;

	// Fixed field widths of the register map and the sample words.
	localparam int STEP_BITS   = 32;
	localparam int AMP_BITS    = 15;
	localparam int SAMPLE_BITS = 16;
	localparam int CFG_IDX_BITS = 3;

	localparam int TBL_SIZE    = 1 << TABLE_BITS;
	localparam int TBL_QUARTER = TBL_SIZE / 4;

	// The deviation product is only needed modulo 2^(PHASE_BITS+15).
	localparam int PROD_BITS = PHASE_BITS + 15;
	localparam int LO_BITS   = SUM_BITS / 2;
	localparam int HI_BITS   = SUM_BITS - LO_BITS;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic [TABLE_BITS-1:0] tbl_idx_t;
	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef sample_t sine_tbl_t [TBL_SIZE];

	// Register map of the configuration port.
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_CARRIER_STEP      = 3'd0,
		CFG_TONE_STEP         = 3'd1,
		CFG_TONE_AMPLITUDE    = 3'd2,
		CFG_DEVIATION_GAIN    = 3'd3,
		CFG_CARRIER_AMPLITUDE = 3'd4,
		CFG_CARRIER_OFFSET    = 3'd5
	} cfg_reg_t;

	// Register reset values.
	localparam logic [STEP_BITS-1:0] RST_CARRIER_STEP   = 32'd429496730;
	localparam logic [STEP_BITS-1:0] RST_TONE_STEP      = 32'd128849019;
	localparam logic [AMP_BITS-1:0]  RST_TONE_AMPLITUDE = 15'd16384;
	localparam logic [STEP_BITS-1:0] RST_DEVIATION_GAIN = 32'd42949673;
	localparam logic [AMP_BITS-1:0]  RST_CARRIER_AMP    = 15'd32767;
	localparam logic [STEP_BITS-1:0] RST_CARRIER_OFFSET = 32'd0;

	// round(32767 * sin(pi/2 * q / TBL_QUARTER)) with a Q30 Taylor series.
	function automatic sample_t quarter_sine(input int unsigned q);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] acc;
		logic [63:0] v;
		x = (HALF_PI_Q30 * 64'(q)) >> (TABLE_BITS - 2);
		x2 = (x * x) >> 30;
		term = x;
		acc = $signed(x);
		for (int n = 1; n <= 6; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - $signed(term);
			end else begin
				acc = acc + $signed(term);
			end
		end
		if (acc < 0) begin
			acc = '0;
		end
		v = ($unsigned(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return sample_t'(v);
	endfunction

	// Full-wave table built from the quarter wave by symmetry.
	function automatic sine_tbl_t build_sine_tbl();
		sine_tbl_t tbl;
		int unsigned quad;
		int unsigned q;
		sample_t s;
		for (int k = 0; k < TBL_SIZE; k++) begin
			quad = k / TBL_QUARTER;
			q = k % TBL_QUARTER;
			s = quarter_sine((quad % 2 == 1) ? (TBL_QUARTER - q) : q);
			tbl[k] = (quad >= 2) ? -s : s;
		end
		return tbl;
	endfunction

endpackage

### hdl/fmtm_sine_rom.sv
`timescale 1ns / 1ps
// Sine lookup memory with one registered read port.
// Depends on fmtm_pkg for the table size and the table builder.
module fmtm_sine_rom (
	input  logic              clk,
	input  logic              rd_en,
	input  fmtm_pkg::tbl_idx_t rd_addr,
	output fmtm_pkg::sample_t  rd_data
);

	// Table contents are fixed at elaboration.
	localparam fmtm_pkg::sine_tbl_t ROM_DATA = fmtm_pkg::build_sine_tbl();

	fmtm_pkg::sample_t rd_data_q;

	// Registered read, held when no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= ROM_DATA[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/fm_tone_modulator_top.sv
`timescale 1ns / 1ps
// FM modulator driven by a sine tone, top level.
// Depends on fmtm_pkg and fmtm_sine_rom.
//
// Usage:
// Each tick word on the tick channel (tick_valid / tick_stall) produces one
// sample word on the sample channel (sample_valid / sample_stall) carrying the
// FM sample, the plain carrier and the tone sample. A tick with restart set
// clears both phases and the message sum before it is processed.
// A tick walks through the sequencer steps from acceptance to the result register: the sine
// memory has a single read port that is used three times per tick, and one
// shared 16x16 multiplier and a two-pass 48x32 deviation product sit in
// between. The block takes one tick at a time, so a new tick is accepted only
// once the last one has finished; tick_stall is high while a tick is in flight.
// The result register decouples the output: a new tick is accepted while the
// previous sample still waits. If that sample is still stalled when the next
// one is ready, the block holds in its last step until the register frees.
// Configuration writes (cfg_valid / cfg_ready, always ready) must be made
// only while the block is idle. Reset clears the phases and the sum and loads
// the register defaults; no clearing pass is needed.
module fm_tone_modulator_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Tick channel.
	input  logic                                 tick_valid,
	output logic                                 tick_stall,
	input  logic                                 restart,
	// Sample channel.
	output logic                                 sample_valid,
	input  logic                                 sample_stall,
	output logic signed [fmtm_pkg::SAMPLE_BITS-1:0] fm_sample,
	output logic signed [fmtm_pkg::SAMPLE_BITS-1:0] carrier_sample,
	output logic signed [fmtm_pkg::SAMPLE_BITS-1:0] tone_sample,
	// Configuration write channel.
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fmtm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [fmtm_pkg::STEP_BITS-1:0]       cfg_data
);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_TONE_RD  = 8'b0000_0010,
		S_TONE_MUL = 8'b0000_0100,
		S_CAR_MUL  = 8'b0000_1000,
		S_DEV_LO   = 8'b0001_0000,
		S_DEV_HI   = 8'b0010_0000,
		S_FM_RD    = 8'b0100_0000,
		S_FM_MUL   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Configuration registers.
	logic [fmtm_pkg::STEP_BITS-1:0] carrier_step_q;
	logic [fmtm_pkg::STEP_BITS-1:0] tone_step_q;
	logic [fmtm_pkg::AMP_BITS-1:0]  tone_amp_q;
	logic [fmtm_pkg::STEP_BITS-1:0] dev_gain_q;
	logic [fmtm_pkg::AMP_BITS-1:0]  carrier_amp_q;
	logic [fmtm_pkg::STEP_BITS-1:0] carrier_offset_q;

	// Modulator state.
	logic [fmtm_pkg::PHASE_BITS-1:0] carrier_phase_q;
	logic [fmtm_pkg::PHASE_BITS-1:0] tone_phase_q;
	logic [fmtm_pkg::SUM_BITS-1:0]   tone_sum_q;

	// Per-tick working registers.
	logic [fmtm_pkg::PHASE_BITS-1:0] base_q;
	logic [fmtm_pkg::PROD_BITS-1:0]  dev_acc_q;
	fmtm_pkg::sample_t               tone_q;
	fmtm_pkg::sample_t               carrier_q;

	// Result register.
	logic              sample_valid_q;
	fmtm_pkg::sample_t fm_out_q;
	fmtm_pkg::sample_t carrier_out_q;
	fmtm_pkg::sample_t tone_out_q;

	logic tick_accept;
	logic out_free;
	logic finish;

	assign tick_stall  = (state_q != S_IDLE);
	assign tick_accept = tick_valid && !tick_stall;
	assign out_free    = !sample_valid_q || !sample_stall;
	assign finish      = (state_q == S_FM_MUL) && out_free;
	assign cfg_ready   = 1'b1;

	// Register writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_step_q   <= fmtm_pkg::RST_CARRIER_STEP;
			tone_step_q      <= fmtm_pkg::RST_TONE_STEP;
			tone_amp_q       <= fmtm_pkg::RST_TONE_AMPLITUDE;
			dev_gain_q       <= fmtm_pkg::RST_DEVIATION_GAIN;
			carrier_amp_q    <= fmtm_pkg::RST_CARRIER_AMP;
			carrier_offset_q <= fmtm_pkg::RST_CARRIER_OFFSET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fmtm_pkg::CFG_CARRIER_STEP:      carrier_step_q   <= cfg_data;
				fmtm_pkg::CFG_TONE_STEP:         tone_step_q      <= cfg_data;
				fmtm_pkg::CFG_TONE_AMPLITUDE:    tone_amp_q       <= cfg_data[fmtm_pkg::AMP_BITS-1:0];
				fmtm_pkg::CFG_DEVIATION_GAIN:    dev_gain_q       <= cfg_data;
				fmtm_pkg::CFG_CARRIER_AMPLITUDE: carrier_amp_q    <= cfg_data[fmtm_pkg::AMP_BITS-1:0];
				fmtm_pkg::CFG_CARRIER_OFFSET:    carrier_offset_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer: one tick walks through all steps in order.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (tick_accept) state_d = S_TONE_RD;
			S_TONE_RD:  state_d = S_TONE_MUL;
			S_TONE_MUL: state_d = S_CAR_MUL;
			S_CAR_MUL:  state_d = S_DEV_LO;
			S_DEV_LO:   state_d = S_DEV_HI;
			S_DEV_HI:   state_d = S_FM_RD;
			S_FM_RD:    state_d = S_FM_MUL;
			S_FM_MUL:   if (out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Deviation phase from the accumulated product, floor of product / 2^15.
	logic [fmtm_pkg::PHASE_BITS-1:0] dev_phase;
	logic [fmtm_pkg::PHASE_BITS-1:0] fm_phase;
	assign dev_phase = dev_acc_q[fmtm_pkg::PROD_BITS-1:15];
	assign fm_phase  = base_q + dev_phase;

	// Sine memory address selection; cosine reads are a quarter turn ahead.
	localparam fmtm_pkg::tbl_idx_t QUARTER_IDX = fmtm_pkg::tbl_idx_t'(fmtm_pkg::TBL_QUARTER);
	logic              rom_rd_en;
	fmtm_pkg::tbl_idx_t rom_addr;
	fmtm_pkg::sample_t  rom_data;

	always_comb begin
		rom_rd_en = 1'b0;
		rom_addr  = tone_phase_q[fmtm_pkg::PHASE_BITS-1 -: fmtm_pkg::TABLE_BITS];
		case (state_q)
			S_TONE_RD: begin
				rom_rd_en = 1'b1;
			end
			S_TONE_MUL: begin
				rom_rd_en = 1'b1;
				rom_addr  = base_q[fmtm_pkg::PHASE_BITS-1 -: fmtm_pkg::TABLE_BITS] + QUARTER_IDX;
			end
			S_FM_RD: begin
				rom_rd_en = 1'b1;
				rom_addr  = fm_phase[fmtm_pkg::PHASE_BITS-1 -: fmtm_pkg::TABLE_BITS] + QUARTER_IDX;
			end
			default: begin
			end
		endcase
	end

	fmtm_sine_rom u_sine_rom (
		.clk     (clk),
		.rd_en   (rom_rd_en),
		.rd_addr (rom_addr),
		.rd_data (rom_data)
	);

	// Shared amplitude scaler: round half up of amp * table value / 2^15.
	logic [fmtm_pkg::AMP_BITS-1:0]  scale_amp;
	logic signed [31:0]             scale_prod;
	logic signed [31:0]             scale_rnd;
	fmtm_pkg::sample_t              scale_res;

	assign scale_amp  = (state_q == S_TONE_MUL) ? tone_amp_q : carrier_amp_q;
	assign scale_prod = $signed({1'b0, scale_amp}) * rom_data;
	assign scale_rnd  = scale_prod + 32'sd16384;
	assign scale_res  = scale_rnd[30:15];

	// Deviation partial products: low half unsigned, high half signed.
	logic [fmtm_pkg::LO_BITS+fmtm_pkg::STEP_BITS-1:0]        dev_lo_prod;
	logic signed [fmtm_pkg::HI_BITS+fmtm_pkg::STEP_BITS:0]   dev_hi_prod;
	logic [fmtm_pkg::PROD_BITS-1:0]                          dev_hi_term;

	assign dev_lo_prod = tone_sum_q[fmtm_pkg::LO_BITS-1:0] * dev_gain_q;
	assign dev_hi_prod = $signed(tone_sum_q[fmtm_pkg::SUM_BITS-1:fmtm_pkg::LO_BITS])
		* $signed({1'b0, dev_gain_q});
	assign dev_hi_term = fmtm_pkg::PROD_BITS'(dev_hi_prod) << fmtm_pkg::LO_BITS;

	// Phase and sum state: cleared by restart, summed once, advanced at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_phase_q <= '0;
			tone_phase_q    <= '0;
			tone_sum_q      <= '0;
		end else begin
			if (tick_accept && restart) begin
				carrier_phase_q <= '0;
				tone_phase_q    <= '0;
				tone_sum_q      <= '0;
			end
			if (state_q == S_CAR_MUL) begin
				tone_sum_q <= tone_sum_q
					+ {{(fmtm_pkg::SUM_BITS - fmtm_pkg::SAMPLE_BITS){tone_q[fmtm_pkg::SAMPLE_BITS-1]}},
					tone_q};
			end
			if (finish) begin
				carrier_phase_q <= carrier_phase_q + fmtm_pkg::PHASE_BITS'(carrier_step_q);
				tone_phase_q    <= tone_phase_q + fmtm_pkg::PHASE_BITS'(tone_step_q);
			end
		end
	end

	// Working registers of one tick.
	always_ff @(posedge clk) begin
		if (state_q == S_TONE_RD) begin
			base_q <= carrier_phase_q + fmtm_pkg::PHASE_BITS'(carrier_offset_q);
		end
		if (state_q == S_TONE_MUL) begin
			tone_q <= scale_res;
		end
		if (state_q == S_CAR_MUL) begin
			carrier_q <= scale_res;
		end
		if (state_q == S_DEV_LO) begin
			dev_acc_q <= fmtm_pkg::PROD_BITS'(dev_lo_prod);
		end
		if (state_q == S_DEV_HI) begin
			dev_acc_q <= dev_acc_q + dev_hi_term;
		end
	end

	// Result register and its valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid_q <= 1'b0;
		end else if (finish) begin
			sample_valid_q <= 1'b1;
		end else if (!sample_stall) begin
			sample_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			fm_out_q      <= scale_res;
			carrier_out_q <= carrier_q;
			tone_out_q    <= tone_q;
		end
	end

	assign sample_valid   = sample_valid_q;
	assign fm_sample      = fm_out_q;
	assign carrier_sample = carrier_out_q;
	assign tone_sample    = tone_out_q;

	// An accepted tick always starts with the tone table read.
	assert property (@(posedge clk) disable iff (!arst_n)
		tick_accept |=> (state_q == S_TONE_RD))
		else $error("accepted tick did not start the sequence");

	// A restart tick begins from time zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		tick_accept && restart |=> (tone_sum_q == '0 && tone_phase_q == '0
			&& carrier_phase_q == '0))
		else $error("restart did not clear phases and sum");

	// A new sample appears only out of the last step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sample_valid) |-> $past(state_q == S_FM_MUL))
		else $error("sample valid raised outside the final step");

	// The final step never overwrites a stalled sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FM_MUL) && sample_valid && sample_stall |=> (state_q == S_FM_MUL))
		else $error("final step left while the result register was blocked");

endmodule
